>>> rtl/utf8_line_break_classifier_top_macros.svh
// Assertion macros used by the line break classifier checker.
`ifndef UTF8_LINE_BREAK_CLASSIFIER_TOP_MACROS_SVH
`define UTF8_LINE_BREAK_CLASSIFIER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, held off in reset.
`define ULBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ulbc check failed");

// Next-cycle implication, sampled on the rising clock, held off in reset.
`define ULBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ulbc check failed");

`endif

>>> rtl/ulbc_pkg.sv
// ----------------------------------------------------------------------------
// ulbc_pkg
// Shared classes, codepoint constants and the queue word of the classifier.
// ----------------------------------------------------------------------------
package ulbc_pkg;

    // line break classes
    localparam logic [2:0] CL_OTHER     = 3'd0;
    localparam logic [2:0] CL_IDEO      = 3'd1;
    localparam logic [2:0] CL_OPEN      = 3'd2;
    localparam logic [2:0] CL_CLOSE     = 3'd3;
    localparam logic [2:0] CL_THAI_BASE = 3'd4;
    localparam logic [2:0] CL_THAI_LEAD = 3'd5;
    localparam logic [2:0] CL_THAI_MARK = 3'd6;

    localparam logic [20:0] REPL_CP = 21'h00FFFD;
    localparam logic [20:0] LF_CP   = 21'h00000A;

    // One queue word per input byte that yields results. The first result is
    // carried in full; a second one is always a newline.
    typedef struct packed {
        logic [20:0] cp;
        logic [2:0]  cls;
        logic        ws;
        logic        nl;
        logic        bad;
        logic        two;
        logic        eot;
    } t_entry;

endpackage

>>> rtl/utf8_line_break_classifier_top.sv
// ----------------------------------------------------------------------------
// utf8_line_break_classifier_top
// UTF-8 decoder with a compact line break classifier.
//
//   channel  dir  handshake          payload
//   input    in   i_valid/o_ready    i_in_byte, i_end_of_text
//   output   out  o_valid/i_ready    o_codepoint .. o_last_of_run
//
// One byte is accepted per cycle while the decode queue has room.
// A byte yields zero, one or two results, sent one at a time through the
// single output register after passing through the queue.
// The QUEUE_DEPTH word queue lets input and output stall apart.
// Reset is synchronous and clears decode, pairing and queue state.
// ----------------------------------------------------------------------------
module utf8_line_break_classifier_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [20:0] o_codepoint,
    output logic [2:0]  o_char_class,
    output logic        o_is_wrap_space,
    output logic        o_is_newline,
    output logic        o_break_before,
    output logic        o_malformed,
    output logic        o_last_of_run
);
    ulbc_pkg::t_entry push_word;
    ulbc_pkg::t_entry head_word;
    logic             push;
    logic             full;
    logic             head_valid;
    logic             pop;

    // decode and classify
    ulbc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .i_full        (full),
        .o_ready       (o_ready),
        .o_push        (push),
        .o_entry       (push_word)
    );

    // decoupling queue
    ulbc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_word),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_data  (head_word)
    );

    // pairing and output
    ulbc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (head_valid),
        .i_q_data        (head_word),
        .o_q_pop         (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_codepoint     (o_codepoint),
        .o_char_class    (o_char_class),
        .o_is_wrap_space (o_is_wrap_space),
        .o_is_newline    (o_is_newline),
        .o_break_before  (o_break_before),
        .o_malformed     (o_malformed),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

>>> rtl/ulbc_fifo.sv
// ----------------------------------------------------------------------------
// ulbc_fifo
// Short register queue of decoded words between decode and output stages.
// ----------------------------------------------------------------------------
module ulbc_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ulbc_pkg::t_entry i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output ulbc_pkg::t_entry o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ulbc_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointer and fill count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> rtl/ulbc_front.sv
// ----------------------------------------------------------------------------
// ulbc_front
// UTF-8 byte decoder and line break classifier; writes one queue word per
// byte that yields results.
// ----------------------------------------------------------------------------
module ulbc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_in_byte,
    input  logic             i_end_of_text,
    input  logic             i_full,
    output logic             o_ready,
    output logic             o_push,
    output ulbc_pkg::t_entry o_entry
);
    logic [20:0] r_part, n_part;
    logic [1:0]  r_rem, n_rem;
    logic        accept;
    logic        has_res;
    logic        single;
    logic [20:0] res_cp;
    logic        res_bad;
    logic        res_two;
    logic [20:0] shifted;

    // class lookup: punctuation first, then Thai, then ideographic ranges
    function automatic logic [2:0] classify(input logic [20:0] cp);
        logic [2:0] c;
        case (cp) inside
            21'h0028, 21'h005B, 21'h007B,
            21'h3008, 21'h300A, 21'h300C, 21'h300E,
            21'h3010, 21'h3014, 21'h3016, 21'h3018,
            21'hFF08, 21'hFF3B, 21'hFF5B,
            21'h201C, 21'h2018:
                c = ulbc_pkg::CL_OPEN;
            21'h0029, 21'h005D, 21'h007D,
            21'h3009, 21'h300B, 21'h300D, 21'h300F,
            21'h3011, 21'h3015, 21'h3017, 21'h3019,
            21'h3001, 21'h3002, 21'h30FB, 21'h30FC,
            21'hFF09, 21'hFF3D, 21'hFF5D, 21'hFF60,
            21'hFF0C, 21'hFF0E, 21'hFF01, 21'hFF1F,
            21'hFF1A, 21'hFF1B,
            21'h201D, 21'h2019:
                c = ulbc_pkg::CL_CLOSE;
            [21'h0E40:21'h0E44]:
                c = ulbc_pkg::CL_THAI_LEAD;
            [21'h0E30:21'h0E3A], 21'h0E45, [21'h0E47:21'h0E4E]:
                c = ulbc_pkg::CL_THAI_MARK;
            [21'h0E00:21'h0E7F]:
                c = ulbc_pkg::CL_THAI_BASE;
            [21'h3040:21'h30FF], [21'h3400:21'h9FFF], [21'hF900:21'hFAFF],
            [21'hAC00:21'hD7A3], [21'h3000:21'h303F], [21'hFF00:21'hFFEF],
            [21'h20000:21'h2FFFF]:
                c = ulbc_pkg::CL_IDEO;
            default:
                c = ulbc_pkg::CL_OTHER;
        endcase
        classify = c;
    endfunction

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign shifted = {r_part[14:0], i_in_byte[5:0]};

    // sequence decode
    always_comb begin
        n_part  = r_part;
        n_rem   = r_rem;
        has_res = 1'b0;
        single  = 1'b0;
        res_cp  = ulbc_pkg::REPL_CP;
        res_bad = 1'b0;
        res_two = 1'b0;
        if (r_rem != 2'd0) begin
            if (i_in_byte == 8'h0A) begin
                // newline cuts the sequence: replacement then newline
                n_part  = '0;
                n_rem   = 2'd0;
                has_res = 1'b1;
                res_bad = 1'b1;
                res_two = 1'b1;
            end else begin
                n_part = shifted;
                n_rem  = r_rem - 2'd1;
                if (r_rem == 2'd1) begin
                    has_res = 1'b1;
                    res_cp  = shifted;
                end
            end
        end else if (!i_in_byte[7]) begin
            has_res = 1'b1;
            single  = 1'b1;
            res_cp  = {13'd0, i_in_byte};
        end else if (i_in_byte[7:5] == 3'b110) begin
            n_part = {16'd0, i_in_byte[4:0]};
            n_rem  = 2'd1;
        end else if (i_in_byte[7:4] == 4'b1110) begin
            n_part = {17'd0, i_in_byte[3:0]};
            n_rem  = 2'd2;
        end else if (i_in_byte[7:3] == 5'b11110) begin
            n_part = {18'd0, i_in_byte[2:0]};
            n_rem  = 2'd3;
        end else begin
            has_res = 1'b1;
            res_bad = 1'b1;
        end
        // end of text: a still open sequence becomes a replacement
        if (i_end_of_text) begin
            if (n_rem != 2'd0) begin
                has_res = 1'b1;
                res_bad = 1'b1;
                res_cp  = ulbc_pkg::REPL_CP;
            end
            n_part = '0;
            n_rem  = 2'd0;
        end
    end

    // queue word
    always_comb begin
        o_entry.cp  = res_cp;
        o_entry.nl  = single && (res_cp == ulbc_pkg::LF_CP);
        o_entry.cls = o_entry.nl ? ulbc_pkg::CL_OTHER : classify(res_cp);
        o_entry.ws  = single && ((res_cp == 21'h20) || (res_cp == 21'h09)
                                 || (res_cp == 21'h0D));
        o_entry.bad = res_bad;
        o_entry.two = res_two;
        o_entry.eot = i_end_of_text;
    end

    assign o_push = accept && has_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part <= '0;
            r_rem  <= '0;
        end else if (accept) begin
            r_part <= n_part;
            r_rem  <= n_rem;
        end
    end

endmodule

>>> rtl/ulbc_back.sv
// ----------------------------------------------------------------------------
// ulbc_back
// Output stage: unpacks queue words into results, tracks pairing state and
// decides break opportunities.
// ----------------------------------------------------------------------------
module ulbc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  ulbc_pkg::t_entry i_q_data,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [20:0]      o_codepoint,
    output logic [2:0]       o_char_class,
    output logic             o_is_wrap_space,
    output logic             o_is_newline,
    output logic             o_break_before,
    output logic             o_malformed,
    output logic             o_last_of_run
);
    logic        r_sub, n_sub;
    logic        r_have_prev, n_have_prev;
    logic [2:0]  r_prev_cls, n_prev_cls;
    logic        r_valid, n_valid;
    logic [20:0] r_cp, n_cp;
    logic [2:0]  r_cls, n_cls;
    logic        r_ws, n_ws;
    logic        r_nl, n_nl;
    logic        r_brk, n_brk;
    logic        r_bad, n_bad;
    logic        r_last, n_last;

    logic        adv;
    logic [20:0] c_cp;
    logic [2:0]  c_cls;
    logic        c_ws, c_nl, c_bad, c_last, c_brk;

    function automatic logic may_break(input logic [2:0] ca, input logic [2:0] cb);
        logic r;
        if (ca == ulbc_pkg::CL_OPEN || cb == ulbc_pkg::CL_CLOSE
            || cb == ulbc_pkg::CL_THAI_MARK) begin
            r = 1'b0;
        end else if (ca == ulbc_pkg::CL_IDEO || cb == ulbc_pkg::CL_IDEO) begin
            r = 1'b1;
        end else if ((ca == ulbc_pkg::CL_THAI_BASE || ca == ulbc_pkg::CL_THAI_MARK)
                     && (cb == ulbc_pkg::CL_THAI_BASE || cb == ulbc_pkg::CL_THAI_LEAD)) begin
            r = 1'b1;
        end else begin
            r = 1'b0;
        end
        may_break = r;
    endfunction

    assign adv     = i_q_valid && (!r_valid || i_ready);
    assign o_q_pop = adv && c_last;

    // select the current result of the head word
    always_comb begin
        if (r_sub) begin
            c_cp  = ulbc_pkg::LF_CP;
            c_cls = ulbc_pkg::CL_OTHER;
            c_ws  = 1'b0;
            c_nl  = 1'b1;
            c_bad = 1'b0;
        end else begin
            c_cp  = i_q_data.cp;
            c_cls = i_q_data.cls;
            c_ws  = i_q_data.ws;
            c_nl  = i_q_data.nl;
            c_bad = i_q_data.bad;
        end
        c_last = r_sub || !i_q_data.two;
        c_brk  = !c_nl && !c_ws && r_have_prev && may_break(r_prev_cls, c_cls);
    end

    // next state
    always_comb begin
        n_sub       = r_sub;
        n_have_prev = r_have_prev;
        n_prev_cls  = r_prev_cls;
        n_valid     = r_valid;
        n_cp        = r_cp;
        n_cls       = r_cls;
        n_ws        = r_ws;
        n_nl        = r_nl;
        n_brk       = r_brk;
        n_bad       = r_bad;
        n_last      = r_last;
        if (adv) begin
            n_valid = 1'b1;
            n_cp    = c_cp;
            n_cls   = c_cls;
            n_ws    = c_ws;
            n_nl    = c_nl;
            n_brk   = c_brk;
            n_bad   = c_bad;
            n_last  = c_last;
            n_sub   = !c_last;
            // pairing: end of text or a space/newline clears it
            if ((c_last && i_q_data.eot) || c_nl || c_ws) begin
                n_have_prev = 1'b0;
                n_prev_cls  = ulbc_pkg::CL_OTHER;
            end else begin
                n_have_prev = 1'b1;
                n_prev_cls  = c_cls;
            end
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub       <= 1'b0;
            r_have_prev <= 1'b0;
            r_prev_cls  <= ulbc_pkg::CL_OTHER;
            r_valid     <= 1'b0;
        end else begin
            r_sub       <= n_sub;
            r_have_prev <= n_have_prev;
            r_prev_cls  <= n_prev_cls;
            r_valid     <= n_valid;
        end
    end

    // output payload, no reset
    always_ff @(posedge i_clk) begin
        r_cp   <= n_cp;
        r_cls  <= n_cls;
        r_ws   <= n_ws;
        r_nl   <= n_nl;
        r_brk  <= n_brk;
        r_bad  <= n_bad;
        r_last <= n_last;
    end

    assign o_valid         = r_valid;
    assign o_codepoint     = r_cp;
    assign o_char_class    = r_cls;
    assign o_is_wrap_space = r_ws;
    assign o_is_newline    = r_nl;
    assign o_break_before  = r_brk;
    assign o_malformed     = r_bad;
    assign o_last_of_run   = r_last;

endmodule

>>> rtl/ulbc_checker.sv
// ----------------------------------------------------------------------------
// ulbc_checker
// Port-level checks of the classifier output, bound to the top level.
// ----------------------------------------------------------------------------
`include "utf8_line_break_classifier_top_macros.svh"

module ulbc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [20:0] o_codepoint,
    input logic [2:0]  o_char_class,
    input logic        o_is_wrap_space,
    input logic        o_is_newline,
    input logic        o_break_before,
    input logic        o_malformed,
    input logic        o_last_of_run
);
    logic        nl_ok;
    logic        bad_ok;
    logic        ws_ok;
    logic [28:0] out_word;

    // expected shape of newline, replacement and wrap space words
    assign nl_ok  = (o_char_class == ulbc_pkg::CL_OTHER) && !o_is_wrap_space
                    && !o_break_before && (o_codepoint == ulbc_pkg::LF_CP);
    assign bad_ok = (o_codepoint == ulbc_pkg::REPL_CP)
                    && (o_char_class == ulbc_pkg::CL_OTHER) && !o_is_newline;
    assign ws_ok  = !o_break_before && !o_is_newline && !o_malformed;

    // full output word
    assign out_word = {o_codepoint, o_char_class, o_is_wrap_space, o_is_newline,
                       o_break_before, o_malformed, o_last_of_run};

    // newline words carry no class and never a break
    `ULBC_ASSERT_NOW(a_newline_plain, i_clk, i_rst_n, o_valid && o_is_newline, nl_ok)

    // replacement words are class other
    `ULBC_ASSERT_NOW(a_malformed_repl, i_clk, i_rst_n, o_valid && o_malformed, bad_ok)

    // a wrap space never opens a break and is never a newline or replacement
    `ULBC_ASSERT_NOW(a_space_nobreak, i_clk, i_rst_n, o_valid && o_is_wrap_space, ws_ok)

    // a stalled output word holds
    `ULBC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(out_word))

endmodule

bind utf8_line_break_classifier_top ulbc_checker u_ulbc_checker (.*);

>>> tb/tb_utf8_line_break_classifier_top.sv
// ----------------------------------------------------------------------------
// tb_utf8_line_break_classifier_top
// Self-checking bench for the UTF-8 decoder and line break classifier.
//
// A byte stream is built up front: a short directed run over the field
// extremes and the malformed cases, then random text made mostly of
// well-formed characters from the classes of interest, mixed with wrap
// spaces, newlines, stray bytes, bad leads and cut sequences. The driver
// sends it in bursts, and the predictor decodes every accepted byte into the
// characters it must produce. The monitor stalls on its own pattern and
// checks each returned character against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_utf8_line_break_classifier_top;

    localparam logic [7:0]  LF_B      = 8'h0A;
    localparam logic [7:0]  TAB_B     = 8'h09;
    localparam logic [7:0]  CR_B      = 8'h0D;
    localparam logic [7:0]  SPACE_B   = 8'h20;
    localparam int          TOTAL_BYTES = 25 + 1150;

    // one byte of text waiting to be sent
    typedef struct packed {
        logic [7:0] data;
        logic       eot;
        logic       drain;  // hold this byte until every prediction is met
    } t_text_byte;

    // one decoded character as the block reports it
    typedef struct packed {
        logic [20:0] cp;
        logic [2:0]  cls;
        logic        ws;
        logic        nl;
        logic        brk;
        logic        bad;
        logic        last;
    } t_char_result;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic [7:0]  i_in_byte       = 8'h00;
    logic        i_end_of_text   = 1'b0;
    logic        i_ready         = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [20:0] o_codepoint;
    logic [2:0]  o_char_class;
    logic        o_is_wrap_space;
    logic        o_is_newline;
    logic        o_break_before;
    logic        o_malformed;
    logic        o_last_of_run;

    t_text_byte   text_bytes[$];
    t_char_result expected_chars[$];
    int           errors     = 0;
    int           chars_seen = 0;
    bit           drain_next = 1'b0;

    // decoder model state
    logic [20:0] partial_cp = '0;
    logic [1:0]  cont_left  = '0;
    logic        prev_valid = 1'b0;
    logic [2:0]  prev_cls   = ulbc_pkg::CL_OTHER;

    utf8_line_break_classifier_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_in_byte       (i_in_byte),
        .i_end_of_text   (i_end_of_text),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_codepoint     (o_codepoint),
        .o_char_class    (o_char_class),
        .o_is_wrap_space (o_is_wrap_space),
        .o_is_newline    (o_is_newline),
        .o_break_before  (o_break_before),
        .o_malformed     (o_malformed),
        .o_last_of_run   (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic logic [2:0] cp_class(input logic [20:0] cp);
        case (cp)
            21'h0028, 21'h005B, 21'h007B,
            21'h3008, 21'h300A, 21'h300C, 21'h300E,
            21'h3010, 21'h3014, 21'h3016, 21'h3018,
            21'hFF08, 21'hFF3B, 21'hFF5B,
            21'h201C, 21'h2018:
                return ulbc_pkg::CL_OPEN;
            21'h0029, 21'h005D, 21'h007D,
            21'h3009, 21'h300B, 21'h300D, 21'h300F,
            21'h3011, 21'h3015, 21'h3017, 21'h3019,
            21'h3001, 21'h3002, 21'h30FB, 21'h30FC,
            21'hFF09, 21'hFF3D, 21'hFF5D, 21'hFF60,
            21'hFF0C, 21'hFF0E, 21'hFF01, 21'hFF1F,
            21'hFF1A, 21'hFF1B,
            21'h201D, 21'h2019:
                return ulbc_pkg::CL_CLOSE;
            default: ;
        endcase
        if (cp >= 21'h0E00 && cp <= 21'h0E7F) begin
            if (cp >= 21'h0E40 && cp <= 21'h0E44)
                return ulbc_pkg::CL_THAI_LEAD;
            if ((cp >= 21'h0E30 && cp <= 21'h0E3A) || cp == 21'h0E45 ||
                (cp >= 21'h0E47 && cp <= 21'h0E4E))
                return ulbc_pkg::CL_THAI_MARK;
            return ulbc_pkg::CL_THAI_BASE;
        end
        if ((cp >= 21'h3040 && cp <= 21'h30FF) || (cp >= 21'h3400 && cp <= 21'h9FFF) ||
            (cp >= 21'hF900 && cp <= 21'hFAFF) || (cp >= 21'hAC00 && cp <= 21'hD7A3) ||
            (cp >= 21'h3000 && cp <= 21'h303F) || (cp >= 21'hFF00 && cp <= 21'hFFEF) ||
            (cp >= 21'h20000 && cp <= 21'h2FFFF))
            return ulbc_pkg::CL_IDEO;
        return ulbc_pkg::CL_OTHER;
    endfunction

    function automatic logic break_ok(input logic [2:0] a, input logic [2:0] b);
        logic a_thai;
        a_thai = (a == ulbc_pkg::CL_THAI_BASE || a == ulbc_pkg::CL_THAI_LEAD ||
                  a == ulbc_pkg::CL_THAI_MARK);
        if (a == ulbc_pkg::CL_OPEN || b == ulbc_pkg::CL_CLOSE || b == ulbc_pkg::CL_THAI_MARK)
            return 1'b0;
        if (a == ulbc_pkg::CL_IDEO || b == ulbc_pkg::CL_IDEO)
            return 1'b1;
        if (a_thai && (b == ulbc_pkg::CL_THAI_BASE || b == ulbc_pkg::CL_THAI_LEAD))
            return a != ulbc_pkg::CL_THAI_LEAD;
        return 1'b0;
    endfunction

    // builds one character and advances the pairing state
    function automatic t_char_result classify_char(input logic [20:0] cp,
                                                   input logic one_byte,
                                                   input logic bad);
        t_char_result r;
        r     = '0;
        r.cp  = cp;
        r.bad = bad;
        if (one_byte && cp == ulbc_pkg::LF_CP) begin
            r.nl       = 1'b1;
            prev_valid = 1'b0;
            prev_cls   = ulbc_pkg::CL_OTHER;
        end else begin
            r.cls = cp_class(cp);
            if (one_byte && (cp == {13'd0, SPACE_B} || cp == {13'd0, TAB_B} ||
                             cp == {13'd0, CR_B})) begin
                r.ws       = 1'b1;
                prev_valid = 1'b0;
                prev_cls   = ulbc_pkg::CL_OTHER;
            end else begin
                r.brk      = prev_valid && break_ok(prev_cls, r.cls);
                prev_valid = 1'b1;
                prev_cls   = r.cls;
            end
        end
        return r;
    endfunction

    // decodes one accepted byte and queues the characters it yields
    task automatic decode_byte(input logic [7:0] b, input logic eot);
        t_char_result res [2];
        int           n;
        n = 0;
        if (cont_left != 2'd0) begin
            if (b == LF_B) begin
                // newline cuts the pending sequence
                cont_left  = 2'd0;
                partial_cp = '0;
                res[0]     = classify_char(ulbc_pkg::REPL_CP, 1'b0, 1'b1);
                res[1]     = classify_char(ulbc_pkg::LF_CP, 1'b1, 1'b0);
                n          = 2;
            end else begin
                partial_cp = {partial_cp[14:0], b[5:0]};
                cont_left  = cont_left - 2'd1;
                if (cont_left == 2'd0) begin
                    res[0] = classify_char(partial_cp, 1'b0, 1'b0);
                    n      = 1;
                end
            end
        end else if (!b[7]) begin
            res[0] = classify_char({13'd0, b}, 1'b1, 1'b0);
            n      = 1;
        end else if (b[7:5] == 3'b110) begin
            partial_cp = {16'd0, b[4:0]};
            cont_left  = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            partial_cp = {17'd0, b[3:0]};
            cont_left  = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            partial_cp = {18'd0, b[2:0]};
            cont_left  = 2'd3;
        end else begin
            res[0] = classify_char(ulbc_pkg::REPL_CP, 1'b0, 1'b1);
            n      = 1;
        end

        // end of text flushes a cut sequence and starts a fresh text
        if (eot) begin
            if (cont_left != 2'd0) begin
                res[n] = classify_char(ulbc_pkg::REPL_CP, 1'b0, 1'b1);
                n      = n + 1;
            end
            cont_left  = 2'd0;
            partial_cp = '0;
            prev_valid = 1'b0;
            prev_cls   = ulbc_pkg::CL_OTHER;
        end

        if (n > 0)
            res[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_chars.push_back(res[i]);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    task automatic add_byte(input logic [7:0] data, input logic eot);
        t_text_byte t;
        t.data     = data;
        t.eot      = eot;
        t.drain    = drain_next;
        drain_next = 1'b0;
        text_bytes.push_back(t);
    endtask

    // continuation byte; now and then with junk in the unchecked top bits
    function automatic logic [7:0] cont_byte(input logic [5:0] bits);
        logic [1:0] top;
        top = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : 2'b10;
        return {top, bits};
    endfunction

    // encodes cp on len bytes, overlong when len exceeds the minimum
    task automatic add_char(input logic [20:0] cp, input int len);
        case (len)
            1: add_byte({1'b0, cp[6:0]}, 1'b0);
            2: begin
                add_byte({3'b110, cp[10:6]}, 1'b0);
                add_byte(cont_byte(cp[5:0]), 1'b0);
            end
            3: begin
                add_byte({4'b1110, cp[15:12]}, 1'b0);
                add_byte(cont_byte(cp[11:6]), 1'b0);
                add_byte(cont_byte(cp[5:0]), 1'b0);
            end
            default: begin
                add_byte({5'b11110, cp[20:18]}, 1'b0);
                add_byte(cont_byte(cp[17:12]), 1'b0);
                add_byte(cont_byte(cp[11:6]), 1'b0);
                add_byte(cont_byte(cp[5:0]), 1'b0);
            end
        endcase
    endtask

    function automatic int min_len(input logic [20:0] cp);
        if (cp < 21'h80)    return 1;
        if (cp < 21'h800)   return 2;
        if (cp < 21'h10000) return 3;
        return 4;
    endfunction

    // codepoints around the class range edges
    function automatic logic [20:0] edge_cp(input int idx);
        logic [20:0] b;
        case (idx)
            0:  b = 21'h0E00;  1:  b = 21'h0E30;  2:  b = 21'h0E3B;
            3:  b = 21'h0E40;  4:  b = 21'h0E45;  5:  b = 21'h0E46;
            6:  b = 21'h0E47;  7:  b = 21'h0E4F;  8:  b = 21'h0E80;
            9:  b = 21'h3000;  10: b = 21'h3040;  11: b = 21'h3100;
            12: b = 21'h3400;  13: b = 21'hA000;  14: b = 21'hAC00;
            15: b = 21'hD7A4;  16: b = 21'hF900;  17: b = 21'hFB00;
            18: b = 21'hFF00;  19: b = 21'hFFF0;  20: b = 21'h20000;
            default: b = 21'h30000;
        endcase
        return b - 21'($urandom_range(0, 1));
    endfunction

    function automatic logic [20:0] pick_cp();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 14)
            return 21'($urandom_range(32'h21, 32'h7E));
        if (sel < 34) begin
            // windows dense in open and close punctuation
            case ($urandom_range(0, 4))
                0:       return 21'($urandom_range(32'h20, 32'h7F));
                1:       return 21'($urandom_range(32'h2018, 32'h201D));
                2:       return 21'($urandom_range(32'h3000, 32'h301F));
                3:       return 21'($urandom_range(32'h30F8, 32'h30FF));
                default: return 21'($urandom_range(32'hFF00, 32'hFF6F));
            endcase
        end
        if (sel < 54)
            return 21'($urandom_range(32'h0E00, 32'h0E7F));
        if (sel < 60)
            return 21'($urandom_range(32'h0E40, 32'h0E44));
        if (sel < 76) begin
            case ($urandom_range(0, 5))
                0:       return 21'($urandom_range(32'h3040, 32'h30FF));
                1:       return 21'($urandom_range(32'h3400, 32'h9FFF));
                2:       return 21'($urandom_range(32'hF900, 32'hFAFF));
                3:       return 21'($urandom_range(32'hAC00, 32'hD7A3));
                4:       return 21'($urandom_range(32'hFF00, 32'hFFEF));
                default: return 21'($urandom_range(32'h20000, 32'h2FFFF));
            endcase
        end
        if (sel < 88)
            return edge_cp($urandom_range(0, 21));
        return 21'($urandom_range(0, 32'h1FFFFF));
    endfunction

    task automatic build_text();
        logic [20:0] cp;
        int          kind;
        int          len;
        int          keep;
        bit          mid_drain;
        mid_drain = 1'b0;

        // directed: extremes, wrap spaces, bad leads, cut sequences, overlong
        add_byte(8'h00, 1'b0);
        add_char(21'h0028, 1);           // open then ideographic: no break
        add_char(21'h4E00, 3);
        add_char(21'h0029, 1);           // close: no break
        add_byte(TAB_B, 1'b0);
        add_byte(8'h80, 1'b0);           // lowest bad lead
        add_byte(8'hFF, 1'b0);           // highest bad lead
        add_byte(8'hC3, 1'b0);           // cut by newline: two results
        add_byte(LF_B, 1'b0);
        add_char(21'h20000, 4);
        add_byte(CR_B, 1'b0);
        add_char({13'd0, SPACE_B}, 2);   // overlong space is not a wrap space
        add_byte(8'hE2, 1'b1);           // cut by end of text
        add_byte(8'h7F, 1'b1);
        add_char(21'h1FFFFF, 4);
        add_byte(LF_B, 1'b0);

        // random text
        drain_next = 1'b1;
        while (text_bytes.size() < TOTAL_BYTES) begin
            if (!mid_drain && text_bytes.size() > TOTAL_BYTES / 2) begin
                mid_drain  = 1'b1;
                drain_next = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 62) begin
                cp  = pick_cp();
                len = min_len(cp);
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(len, 4);
                add_char(cp, len);
            end else if (kind < 72) begin
                case ($urandom_range(0, 3))
                    0:       add_byte(SPACE_B, 1'b0);
                    1:       add_byte(TAB_B, 1'b0);
                    2:       add_byte(CR_B, 1'b0);
                    default: add_byte(LF_B, 1'b0);
                endcase
            end else if (kind < 80) begin
                add_byte(8'($urandom_range(0, 255)), 1'b0);
            end else if (kind < 88) begin
                // sequence cut short by a newline or end of text, or fed a stray byte
                len = $urandom_range(2, 4);
                case (len)
                    2:       add_byte({3'b110, 5'($urandom)}, 1'b0);
                    3:       add_byte({4'b1110, 4'($urandom)}, 1'b0);
                    default: add_byte({5'b11110, 3'($urandom)}, 1'b0);
                endcase
                keep = $urandom_range(0, len - 2);
                for (int i = 0; i < keep; i++)
                    add_byte(cont_byte(6'($urandom)), 1'b0);
                case ($urandom_range(0, 2))
                    0:       add_byte(LF_B, 1'b0);
                    1:       text_bytes[text_bytes.size()-1].eot = 1'b1;
                    default: add_byte(8'($urandom_range(0, 255)), 1'b0);
                endcase
            end else if (kind < 94) begin
                if ($urandom_range(0, 1))
                    add_byte(8'($urandom_range(32'h80, 32'hBF)), 1'b0);
                else
                    add_byte(8'($urandom_range(32'hF8, 32'hFF)), 1'b0);
            end else begin
                text_bytes[text_bytes.size()-1].eot = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: bursts with random gaps, valid held until accepted
    // ------------------------------------------------------------------------
    int         burst_left = 0;
    int         gap_left   = 0;
    logic       offer;
    t_text_byte next_byte;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            offer = i_valid;
            if (i_valid && o_ready) begin
                decode_byte(i_in_byte, i_end_of_text);
                offer = 1'b0;
            end
            if (!offer && text_bytes.size() != 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!(text_bytes[0].drain && expected_chars.size() != 0)) begin
                    next_byte      = text_bytes.pop_front();
                    i_in_byte     <= next_byte.data;
                    i_end_of_text <= next_byte.eot;
                    offer          = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
                                                                 : $urandom_range(0, 3);
                    end
                end
            end
            i_valid <= offer;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: stall pattern per window, one long hold, result check
    // ------------------------------------------------------------------------
    int   ready_mode     = 0;
    int   mode_left      = 0;
    int   hold_left      = 0;
    bit   long_hold_done = 1'b0;
    logic take;

    task automatic check_char();
        t_char_result got;
        t_char_result want;
        got = {o_codepoint, o_char_class, o_is_wrap_space, o_is_newline,
               o_break_before, o_malformed, o_last_of_run};
        chars_seen++;
        if (expected_chars.size() == 0) begin
            $display("%0t: unexpected word cp=%h cls=%0d", $time, got.cp, got.cls);
            errors++;
        end else begin
            want = expected_chars.pop_front();
            if (got !== want) begin
                $display("%0t: word %0d mismatch: expected cp=%h cls=%0d ws=%b nl=%b brk=%b bad=%b last=%b",
                         $time, chars_seen, want.cp, want.cls, want.ws, want.nl,
                         want.brk, want.bad, want.last);
                $display("%0t: word %0d             actual cp=%h cls=%0d ws=%b nl=%b brk=%b bad=%b last=%b",
                         $time, chars_seen, got.cp, got.cls, got.ws, got.nl,
                         got.brk, got.bad, got.last);
                errors++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready)
                check_char();
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 96);
            end else begin
                mode_left--;
            end
            // one long hold so the block backs up into its input
            if (!long_hold_done && chars_seen >= 400) begin
                long_hold_done = 1'b1;
                hold_left      = 100;
            end
            if (hold_left > 0) begin
                hold_left--;
                take = 1'b0;
            end else begin
                case (ready_mode)
                    0:       take = 1'b1;
                    1:       take = 1'($urandom_range(0, 1));
                    2:       take = (mode_left % 4 == 0);
                    default: take = ($urandom_range(0, 9) != 0);
                endcase
            end
            i_ready <= take;
        end
    end

    // ------------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------------
    initial begin
        build_text();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (text_bytes.size() != 0 || i_valid)
            @(posedge i_clk);
        while (expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("tb_utf8_line_break_classifier_top: done, clean");
        else
            $display("tb_utf8_line_break_classifier_top: done, errors");
        $finish;
    end

    initial begin
        #2000000;
        $display("%0t: timeout, %0d words still expected", $time, expected_chars.size());
        $display("tb_utf8_line_break_classifier_top: done, errors");
        $finish;
    end

endmodule
